// ===== rtl/lplt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lplt_pkg
// Shared constants and types for the linear probe label table: table size,
// field widths, request and status codes, the slot word and the controller
// states.
// ----------------------------------------------------------------------------
package lplt_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int KEY_W    = 64;
    localparam int PAY_W    = 64;
    localparam int COUNT_W  = 11;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = COUNT_W'(512);

    // request codes
    localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_slot;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ===== rtl/linear_probe_label_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_label_table
// Open-addressed key/payload table with linear probing, held in one
// synchronous slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on i_valid/o_ready with i_action, i_key and i_payload;
//   one result per request leaves on o_valid/i_ready with o_status,
//   o_found_payload and o_entry_count. i_cfg_we writes max_entries at once.
//   Register and lookup requests read one slot per cycle starting at the
//   home slot (low key bits). A request goes from acceptance through the
//   probe state and the done state into the output register, and the next
//   request is taken only once the block is back in idle; the probe loop on
//   the single memory read port sets this. The slot memory is written only
//   at the end of a request, before the next request's first read.
//   A clear request sweeps the slot memory, one slot a cycle, and answers
//   once the sweep is done. After reset the same sweep runs before o_ready
//   first rises; config writes are taken meanwhile.
//   A result waiting on a stalled receiver sits in the output register; the
//   block still accepts the next request and holds its result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module linear_probe_label_table
    import lplt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [PAY_W-1:0]   i_payload,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [PAY_W-1:0]   o_found_payload,
    output logic [COUNT_W-1:0] o_entry_count
);

    t_slot mem [CAPACITY];
    t_slot r_rd_data;

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_max_entries;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0]  r_probes, n_probes;
    logic [ACT_W-1:0]   r_action, n_action;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PAY_W-1:0]   r_payload, n_payload;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic [PAY_W-1:0]   r_res_found, n_res_found;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [PAY_W-1:0]   r_out_found, n_out_found;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic              accept;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot             wr_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              slot_match;
    logic              slot_empty;
    logic              last_probe;
    logic              out_free;

    assign o_ready         = (r_state == S_IDLE);
    assign accept          = i_valid && o_ready;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found_payload = r_out_found;
    assign o_entry_count   = r_out_count;
    assign out_free        = !r_out_valid || i_ready;

    assign slot_empty = !r_rd_data.valid;
    assign slot_match = r_rd_data.valid && (r_rd_data.key == r_key);
    assign last_probe = (r_probes == {SLOT_W{1'b1}});

    // slot memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_action     = r_action;
        n_key        = r_key;
        n_payload    = r_payload;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        wr_en        = 1'b0;
        wr_addr      = r_slot;
        wr_data      = '{valid: 1'b1, key: r_key, payload: r_payload};
        rd_addr      = r_slot + SLOT_W'(1);

        case (r_state)
            S_INIT, S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = '0;
                n_slot  = r_slot + SLOT_W'(1);
                if (r_slot == {SLOT_W{1'b1}}) begin
                    if (r_state == S_INIT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_count      = '0;
                        n_res_status = ST_CLEARED;
                        n_res_found  = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_IDLE: begin
                rd_addr = i_key[SLOT_W-1:0];
                if (accept) begin
                    n_action    = i_action;
                    n_key       = i_key;
                    n_payload   = i_payload;
                    n_slot      = i_key[SLOT_W-1:0];
                    n_probes    = '0;
                    n_res_found = '0;
                    case (i_action)
                        ACT_REGISTER, ACT_LOOKUP: begin
                            n_state = S_PROBE;
                        end
                        ACT_CLEAR: begin
                            n_slot  = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_res_status = ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (slot_match) begin
                    n_state = S_DONE;
                    if (r_action == ACT_REGISTER) begin
                        wr_en        = 1'b1;
                        n_res_status = ST_UPDATED;
                    end else begin
                        n_res_status = ST_FOUND;
                        n_res_found  = r_rd_data.payload;
                    end
                end else if (slot_empty) begin
                    n_state = S_DONE;
                    if (r_action != ACT_REGISTER) begin
                        n_res_status = ST_NOT_FOUND;
                    end else if (r_count >= r_max_entries) begin
                        n_res_status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        n_count      = r_count + COUNT_W'(1);
                        n_res_status = ST_INSERTED;
                    end
                end else if (last_probe) begin
                    // every slot taken by other keys
                    n_state      = S_DONE;
                    n_res_status = (r_action == ACT_REGISTER) ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    n_slot   = r_slot + SLOT_W'(1);
                    n_probes = r_probes + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_slot  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_slot        <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_max_entries <= MAX_ENTRIES_RST;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probes     <= n_probes;
        r_action     <= n_action;
        r_key        <= n_key;
        r_payload    <= n_payload;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    // an insert only happens below the limit and bumps the count by one
    a_insert_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && wr_en && slot_empty) |->
            (r_count < r_max_entries && n_count == r_count + COUNT_W'(1)))
        else $error("insert past limit or bad count update");

    // a new result only comes out of the done state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !i_ready)) |-> (r_state == S_DONE))
        else $error("result loaded outside done state");

    // the memory is written only while sweeping or at the end of a probe
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_INIT || r_state == S_CLEAR ||
                   (r_state == S_PROBE && (slot_match || slot_empty))))
        else $error("unexpected slot write");

    // an insert result never reports an empty table
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_INSERTED) |-> (o_entry_count != '0))
        else $error("insert reported with empty table");

endmodule
